FILE: rtl/fused_bloomier_filter_lookup_defines.svh
// Assertion macros used by the checker file of the lookup block.
`ifndef FUSED_BLOOMIER_FILTER_LOOKUP_DEFINES_SVH
`define FUSED_BLOOMIER_FILTER_LOOKUP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FBL_CHK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: same cycle");

// Next-cycle implication, sampled on clk, off during reset.
`define FBL_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next cycle");

`endif

FILE: rtl/fbl_pkg.sv
// Types and constants shared by the filter lookup modules.
package fbl_pkg;

    localparam int NUM_HASHES = 6;

    localparam logic [31:0] MIX_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2 = 32'h1b873593;
    localparam logic [31:0] MIX_C3 = 32'he6546b64;
    localparam logic [31:0] FIN_C1 = 32'h85ebca6b;
    localparam logic [31:0] FIN_C2 = 32'hc2b2ae35;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_WR_FP  = 2'd2;
    localparam logic [1:0] OP_WR_VAL = 2'd3;

    localparam logic [2:0] CFG_HASH_COUNT    = 3'd0;
    localparam logic [2:0] CFG_FUSED_MODE    = 3'd1;
    localparam logic [2:0] CFG_SLOT_COUNT    = 3'd2;
    localparam logic [2:0] CFG_SEGMENT_LOG2  = 3'd3;
    localparam logic [2:0] CFG_SEGMENT_COUNT = 3'd4;
    localparam logic [2:0] CFG_SEEDS_01      = 3'd5;
    localparam logic [2:0] CFG_SEEDS_23      = 3'd6;
    localparam logic [2:0] CFG_SEEDS_45      = 3'd7;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] key_word;
        logic [2:0]  word_bytes;
        logic        key_last;
        logic [11:0] slot_index;
        logic [7:0]  slot_data;
        logic [31:0] new_value;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [11:0] slot;
        logic [31:0] value_out;
    } out_item_t;

    typedef struct packed {
        logic [2:0]                  hash_count;
        logic                        fused_mode;
        logic [12:0]                 slot_count;
        logic [3:0]                  segment_log2;
        logic [12:0]                 segment_count;
        logic [NUM_HASHES-1:0][31:0] seeds;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                  op;
        logic [NUM_HASHES-1:0][31:0] hashes;
        logic [11:0]                 slot_index;
        logic [7:0]                  slot_data;
        logic [31:0]                 new_value;
    } job_t;

endpackage

FILE: rtl/fbl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/fbl_rem.sv
// Iterative remainder unit: 32-bit dividend by 13-bit divisor, one bit a cycle.
module fbl_rem (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [12:0] divisor,
    output logic        done,
    output logic [12:0] rem
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] dvd_reg;
    logic [12:0] rem_reg;
    logic [13:0] trial;
    logic [13:0] diff;
    logic [12:0] rem_step;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[31]};
        diff     = trial - {1'b0, divisor};
        rem_step = (trial >= {1'b0, divisor}) ? diff[12:0] : trial[12:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= 13'd0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            rem_reg <= rem_step;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

FILE: rtl/fbl_queue.sv
// Two-entry job queue between the hashing front and the table back end.
module fbl_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fbl_pkg::job_t push_data,
    input  logic          pop,
    output fbl_pkg::job_t head,
    output logic          full,
    output logic          empty
);

    fbl_pkg::job_t mem_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/fbl_front.sv
// Front end: accept items, run the per-word hash rounds and finalize keys.
module fbl_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  fbl_pkg::in_item_t in_data,
    input  fbl_pkg::cfg_t     cfg,
    output logic              q_push,
    output fbl_pkg::job_t     q_data,
    input  logic              q_full
);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_M2   = 3'd1;
    localparam logic [2:0] F_UPD  = 3'd2;
    localparam logic [2:0] F_FIN1 = 3'd3;
    localparam logic [2:0] F_FIN2 = 3'd4;
    localparam logic [2:0] F_FIN3 = 3'd5;
    localparam logic [2:0] F_PUSH = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       in_key_reg, in_key_next;
    logic [2:0] i_reg, i_next;

    fbl_pkg::in_item_t item_reg;
    logic [2:0]        nb_reg;
    logic [31:0]       hs_reg [fbl_pkg::NUM_HASHES];
    logic [31:0]       len_reg;
    logic [31:0]       m_reg;

    logic        accept;
    logic        key_op;
    logic [2:0]  nb_in;
    logic [31:0] operand;
    logic [31:0] upd_hs [fbl_pkg::NUM_HASHES];
    logic [31:0] mix_rot;
    logic [31:0] fin_a;
    logic [31:0] fin_b;
    logic [31:0] fin_c;

    assign in_stall = (state_reg != F_IDLE);
    assign accept   = in_valid && !in_stall;
    assign key_op   = (in_data.operation == fbl_pkg::OP_LOOKUP)
                   || (in_data.operation == fbl_pkg::OP_SET);

    always_comb
    begin
        // count every non-last word, and any byte count above four, as full
        if (!in_data.key_last || (in_data.word_bytes > 3'd4))
        begin
            nb_in = 3'd4;
        end
        else
        begin
            nb_in = in_data.word_bytes;
        end
        unique case (nb_in)
            3'd0:    operand = 32'd0;
            3'd1:    operand = {24'd0, in_data.key_word[7:0]};
            3'd2:    operand = {16'd0, in_data.key_word[15:0]};
            3'd3:    operand = {8'd0, in_data.key_word[23:0]};
            default: operand = in_data.key_word;
        endcase
    end

    always_comb
    begin
        logic [31:0] x;
        logic [31:0] r;
        mix_rot = {m_reg[16:0], m_reg[31:17]};
        for (int n = 0; n < fbl_pkg::NUM_HASHES; n++)
        begin
            x = hs_reg[n] ^ m_reg;
            r = {x[18:0], x[31:19]};
            if (nb_reg == 3'd4)
            begin
                upd_hs[n] = r + {r[29:0], 2'b00} + fbl_pkg::MIX_C3;
            end
            else
            begin
                upd_hs[n] = x;
            end
        end
        fin_a = hs_reg[i_reg] ^ len_reg;
        fin_a = fin_a ^ (fin_a >> 16);
        fin_b = m_reg ^ (m_reg >> 13);
        fin_c = m_reg ^ (m_reg >> 16);
    end

    always_comb
    begin
        state_next  = state_reg;
        in_key_next = in_key_reg;
        i_next      = i_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (key_op)
                    begin
                        in_key_next = 1'b1;
                        state_next  = F_M2;
                    end
                    else
                    begin
                        state_next = F_PUSH;
                    end
                end
            end
            F_M2:
            begin
                state_next = F_UPD;
            end
            F_UPD:
            begin
                if (item_reg.key_last)
                begin
                    i_next     = 3'd0;
                    state_next = F_FIN1;
                end
                else
                begin
                    state_next = F_IDLE;
                end
            end
            F_FIN1:
            begin
                state_next = F_FIN2;
            end
            F_FIN2:
            begin
                state_next = F_FIN3;
            end
            F_FIN3:
            begin
                if (i_reg == 3'(fbl_pkg::NUM_HASHES - 1))
                begin
                    state_next = F_PUSH;
                end
                else
                begin
                    i_next     = i_reg + 3'd1;
                    state_next = F_FIN1;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    // a finished key leaves the key-in-progress state
                    if ((item_reg.operation == fbl_pkg::OP_LOOKUP)
                        || (item_reg.operation == fbl_pkg::OP_SET))
                    begin
                        in_key_next = 1'b0;
                    end
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            in_key_reg <= 1'b0;
            i_reg      <= 3'd0;
        end
        else
        begin
            state_reg  <= state_next;
            in_key_reg <= in_key_next;
            i_reg      <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    item_reg <= in_data;
                    nb_reg   <= nb_in;
                    m_reg    <= operand * fbl_pkg::MIX_C1;
                    if (key_op && !in_key_reg)
                    begin
                        for (int n = 0; n < fbl_pkg::NUM_HASHES; n++)
                        begin
                            hs_reg[n] <= cfg.seeds[n];
                        end
                        len_reg <= 32'd0;
                    end
                end
            end
            F_M2:
            begin
                m_reg <= mix_rot * fbl_pkg::MIX_C2;
            end
            F_UPD:
            begin
                for (int n = 0; n < fbl_pkg::NUM_HASHES; n++)
                begin
                    hs_reg[n] <= upd_hs[n];
                end
                len_reg <= len_reg + {29'd0, nb_reg};
            end
            F_FIN1:
            begin
                m_reg <= fin_a * fbl_pkg::FIN_C1;
            end
            F_FIN2:
            begin
                m_reg <= fin_b * fbl_pkg::FIN_C2;
            end
            F_FIN3:
            begin
                hs_reg[i_reg] <= fin_c;
            end
            default:
            begin
            end
        endcase
    end

    assign q_push = (state_reg == F_PUSH) && !q_full;

    always_comb
    begin
        q_data.op         = item_reg.operation;
        q_data.slot_index = item_reg.slot_index;
        q_data.slot_data  = item_reg.slot_data;
        q_data.new_value  = item_reg.new_value;
        for (int n = 0; n < fbl_pkg::NUM_HASHES; n++)
        begin
            q_data.hashes[n] = hs_reg[n];
        end
    end

endmodule

FILE: rtl/fbl_back.sv
// Back end: form locations, decode the fingerprint and access the value table.
module fbl_back #(
    parameter int TABLE_DEPTH = 4096,
    parameter int SLOT_BITS   = 8,
    parameter int VALUE_BITS  = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    output logic               q_pop,
    input  fbl_pkg::job_t      q_head,
    input  fbl_pkg::cfg_t      cfg,
    output logic               out_valid,
    input  logic               out_stall,
    output fbl_pkg::out_item_t out_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    localparam logic [3:0] B_IDLE   = 4'd0;
    localparam logic [3:0] B_DISP   = 4'd1;
    localparam logic [3:0] B_DSTART = 4'd2;
    localparam logic [3:0] B_DWAIT  = 4'd3;
    localparam logic [3:0] B_LOC    = 4'd4;
    localparam logic [3:0] B_FPRD   = 4'd5;
    localparam logic [3:0] B_FPWT   = 4'd6;
    localparam logic [3:0] B_SEL    = 4'd7;
    localparam logic [3:0] B_VACC   = 4'd8;
    localparam logic [3:0] B_VWT    = 4'd9;
    localparam logic [3:0] B_OUT    = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [1:0] j_reg, j_next;
    logic       ok_reg, ok_next;
    logic       out_valid_reg, out_valid_next;

    fbl_pkg::job_t      job_reg;
    logic [12:0]        first_reg;
    logic [SLOT_BITS-1:0] sel_reg;
    logic [ADDR_W-1:0]  loc_reg [4];
    logic               found_reg;
    logic [11:0]        slot_reg;
    logic [31:0]        vout_reg;
    fbl_pkg::out_item_t out_data_reg;

    logic [2:0]  k;
    logic [1:0]  k_last;
    logic [2:0]  hsel;
    logic [31:0] hval;
    logic [12:0] divisor;
    logic        rem_done;
    logic [12:0] rem;
    logic [31:0] seg_mask;
    logic [31:0] loc_cand;
    logic        in_range;
    logic        ok_new;
    logic [31:0] idx_wide;
    logic        idx_ok;
    logic        job_key;
    logic        out_load;
    logic [31:0] loc_wide;

    logic                  fp_we;
    logic [SLOT_BITS-1:0]  fp_wdata;
    logic [SLOT_BITS-1:0]  fp_rdata;
    logic                  val_we;
    logic [ADDR_W-1:0]     val_waddr;
    logic [VALUE_BITS-1:0] val_wdata;
    logic [VALUE_BITS-1:0] val_rdata;
    logic [63:0]           fp_data_wide;
    logic [63:0]           val_wide;
    logic [63:0]           rd_wide;

    always_comb
    begin
        // out-of-range hash counts clamp to three or four
        if (cfg.hash_count < 3'd3)
        begin
            k = 3'd3;
        end
        else if (cfg.hash_count > 3'd4)
        begin
            k = 3'd4;
        end
        else
        begin
            k = cfg.hash_count;
        end
        k_last = 2'(k - 3'd1);
    end

    always_comb
    begin
        unique case (state_reg)
            B_DSTART: hsel = cfg.fused_mode ? (k + 3'd1) : {1'b0, j_reg};
            B_FPRD:   hsel = k;
            default:  hsel = {1'b0, j_reg};
        endcase
        hval    = job_reg.hashes[hsel];
        divisor = cfg.fused_mode ? (cfg.segment_count - {10'd0, k}) : cfg.slot_count;
    end

    always_comb
    begin
        seg_mask = (32'd1 << cfg.segment_log2) - 32'd1;
        if (state_reg == B_LOC)
        begin
            loc_cand = ({19'd0, first_reg} << cfg.segment_log2)
                     + ({30'd0, j_reg} << cfg.segment_log2)
                     + (hval & seg_mask);
        end
        else
        begin
            loc_cand = {19'd0, rem};
        end
        in_range = (loc_cand < 32'(TABLE_DEPTH));
        ok_new   = ok_reg && in_range;
        idx_wide = {20'd0, job_reg.slot_index};
        idx_ok   = (idx_wide < 32'(TABLE_DEPTH));
        job_key  = (job_reg.op == fbl_pkg::OP_LOOKUP) || (job_reg.op == fbl_pkg::OP_SET);
        out_load = (state_reg == B_OUT) && (!out_valid_reg || !out_stall);
        loc_wide = 32'(loc_reg[j_reg]);
    end

    assign q_pop = (state_reg == B_IDLE) && !q_empty;

    always_comb
    begin
        state_next     = state_reg;
        j_next         = j_reg;
        ok_next        = ok_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = B_DISP;
                end
            end
            B_DISP:
            begin
                j_next  = 2'd0;
                ok_next = 1'b1;
                if (!job_key)
                begin
                    state_next = B_IDLE;
                end
                else if (cfg.fused_mode)
                begin
                    state_next = (cfg.segment_count <= {10'd0, k}) ? B_OUT : B_DSTART;
                end
                else
                begin
                    state_next = (cfg.slot_count == 13'd0) ? B_OUT : B_DSTART;
                end
            end
            B_DSTART:
            begin
                state_next = B_DWAIT;
            end
            B_DWAIT:
            begin
                if (rem_done)
                begin
                    if (cfg.fused_mode)
                    begin
                        j_next     = 2'd0;
                        state_next = B_LOC;
                    end
                    else
                    begin
                        ok_next = ok_new;
                        if (j_reg == k_last)
                        begin
                            j_next     = 2'd0;
                            state_next = ok_new ? B_FPRD : B_OUT;
                        end
                        else
                        begin
                            j_next     = j_reg + 2'd1;
                            state_next = B_DSTART;
                        end
                    end
                end
            end
            B_LOC:
            begin
                ok_next = ok_new;
                if (j_reg == k_last)
                begin
                    j_next     = 2'd0;
                    state_next = ok_new ? B_FPRD : B_OUT;
                end
                else
                begin
                    j_next = j_reg + 2'd1;
                end
            end
            B_FPRD:
            begin
                state_next = B_FPWT;
            end
            B_FPWT:
            begin
                if (j_reg == k_last)
                begin
                    state_next = B_SEL;
                end
                else
                begin
                    j_next     = j_reg + 2'd1;
                    state_next = B_FPRD;
                end
            end
            B_SEL:
            begin
                if (sel_reg < SLOT_BITS'(k))
                begin
                    j_next     = sel_reg[1:0];
                    state_next = B_VACC;
                end
                else
                begin
                    state_next = B_OUT;
                end
            end
            B_VACC:
            begin
                state_next = (job_reg.op == fbl_pkg::OP_SET) ? B_OUT : B_VWT;
            end
            B_VWT:
            begin
                state_next = B_OUT;
            end
            B_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            j_reg         <= 2'd0;
            ok_reg        <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    job_reg <= q_head;
                end
            end
            B_DISP:
            begin
                found_reg <= 1'b0;
                slot_reg  <= 12'd0;
                vout_reg  <= 32'd0;
            end
            B_DWAIT:
            begin
                if (rem_done)
                begin
                    if (cfg.fused_mode)
                    begin
                        first_reg <= rem;
                    end
                    else
                    begin
                        loc_reg[j_reg] <= loc_cand[ADDR_W-1:0];
                    end
                end
            end
            B_LOC:
            begin
                loc_reg[j_reg] <= loc_cand[ADDR_W-1:0];
            end
            B_FPRD:
            begin
                if (j_reg == 2'd0)
                begin
                    sel_reg <= hval[SLOT_BITS-1:0];
                end
            end
            B_FPWT:
            begin
                sel_reg <= sel_reg ^ fp_rdata;
            end
            B_VACC:
            begin
                found_reg <= 1'b1;
                slot_reg  <= loc_wide[11:0];
            end
            B_VWT:
            begin
                vout_reg <= rd_wide[31:0];
            end
            B_OUT:
            begin
                if (out_load)
                begin
                    out_data_reg.found     <= found_reg;
                    out_data_reg.slot      <= slot_reg;
                    out_data_reg.value_out <= vout_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        fp_data_wide = {56'd0, job_reg.slot_data};
        val_wide     = {32'd0, job_reg.new_value};
        rd_wide      = 64'(val_rdata);
        fp_wdata     = fp_data_wide[SLOT_BITS-1:0];
        val_wdata    = val_wide[VALUE_BITS-1:0];
        fp_we        = (state_reg == B_DISP) && (job_reg.op == fbl_pkg::OP_WR_FP) && idx_ok;
        if (state_reg == B_DISP)
        begin
            val_we    = (job_reg.op == fbl_pkg::OP_WR_VAL) && idx_ok;
            val_waddr = idx_wide[ADDR_W-1:0];
        end
        else
        begin
            val_we    = (state_reg == B_VACC) && (job_reg.op == fbl_pkg::OP_SET);
            val_waddr = loc_reg[j_reg];
        end
    end

    fbl_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == B_DSTART),
        .dividend (hval),
        .divisor  (divisor),
        .done     (rem_done),
        .rem      (rem)
    );

    fbl_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_fp_ram (
        .clk   (clk),
        .we    (fp_we),
        .waddr (idx_wide[ADDR_W-1:0]),
        .wdata (fp_wdata),
        .raddr (loc_reg[j_reg]),
        .rdata (fp_rdata)
    );

    fbl_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (loc_reg[j_reg]),
        .rdata (val_rdata)
    );

endmodule

FILE: rtl/fused_bloomier_filter_lookup.sv
// Front: each key word is mixed and folded into the running hashes; a last key word is then
// finalized one hash at a time on one shared multiplier pair. A table write goes straight to
// the queue; in_stall holds the input while the front is busy. Back end: fused mode runs one
// remainder, unfused one for each of the k (3 or 4) locations; a set skips the value read wait.
// Reset: control state, queue and config registers clear asynchronously on rst_n low;
// table contents are undefined until written and get no clearing pass.
module fused_bloomier_filter_lookup #(
    parameter int TABLE_DEPTH = 4096,
    parameter int SLOT_BITS   = 8,
    parameter int VALUE_BITS  = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  fbl_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output fbl_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    // Config registers; software must write them only while the block is quiet (not enforced here).
    fbl_pkg::cfg_t cfg_reg;

    fbl_pkg::job_t push_data;
    fbl_pkg::job_t head;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;

    // Config is always accepted: a transfer completes on any valid cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hash_count    <= 3'd3;
            cfg_reg.fused_mode    <= 1'b1;
            cfg_reg.slot_count    <= 13'd4096;
            cfg_reg.segment_log2  <= 4'd0;
            cfg_reg.segment_count <= 13'd1;
            cfg_reg.seeds         <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fbl_pkg::CFG_HASH_COUNT:    cfg_reg.hash_count    <= cfg_data[2:0];
                fbl_pkg::CFG_FUSED_MODE:    cfg_reg.fused_mode    <= cfg_data[0];
                fbl_pkg::CFG_SLOT_COUNT:    cfg_reg.slot_count    <= cfg_data[12:0];
                fbl_pkg::CFG_SEGMENT_LOG2:  cfg_reg.segment_log2  <= cfg_data[3:0];
                fbl_pkg::CFG_SEGMENT_COUNT: cfg_reg.segment_count <= cfg_data[12:0];
                fbl_pkg::CFG_SEEDS_01:
                begin
                    cfg_reg.seeds[0] <= cfg_data[31:0];
                    cfg_reg.seeds[1] <= cfg_data[63:32];
                end
                fbl_pkg::CFG_SEEDS_23:
                begin
                    cfg_reg.seeds[2] <= cfg_data[31:0];
                    cfg_reg.seeds[3] <= cfg_data[63:32];
                end
                fbl_pkg::CFG_SEEDS_45:
                begin
                    cfg_reg.seeds[4] <= cfg_data[31:0];
                    cfg_reg.seeds[5] <= cfg_data[63:32];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Front: hash key words and emit one job per finished key or table write.
    fbl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .q_push   (push),
        .q_data   (push_data),
        .q_full   (full)
    );

    // Queue: keep job order so table writes and lookups stay in sequence.
    fbl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    // Back end: locate, decode, access tables, hold the result register.
    fbl_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SLOT_BITS   (SLOT_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (empty),
        .q_pop     (pop),
        .q_head    (head),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: rtl/fbl_checker.sv
// Port-level checks for the filter lookup block and their bind.
`include "fused_bloomier_filter_lookup_defines.svh"

module fbl_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input fbl_pkg::out_item_t out_data
);

    `FBL_CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `FBL_CHK_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))
    `FBL_CHK_NOW(a_miss_zero, out_valid && !out_data.found, {out_data.slot, out_data.value_out} == '0)
    `FBL_CHK_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall)

endmodule

bind fused_bloomier_filter_lookup fbl_checker u_fbl_checker (.*);

FILE: tb/sv/fused_bloomier_filter_lookup_tb.sv
// Self-checking testbench for the fused Bloomier filter lookup block.
module fused_bloomier_filter_lookup_tb;
    import fbl_pkg::*;

    typedef bit [31:0] hash_set_t [NUM_HASHES];

    localparam int DEPTH       = 4096;
    localparam int LOADED      = 32;      // entries loaded up front; random layouts stay inside
    localparam int DRAIN_WAIT  = 400;     // longest back end pass, with margin
    localparam int STALL_LIMIT = 20000;   // cycles with no transfer anywhere

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [63:0] cfg_data;

    fused_bloomier_filter_lookup dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Shadow copy of the block: configuration, hash state and both tables.
    bit [2:0]  hash_count_q;
    bit        fused_q;
    bit [12:0] slot_count_q;
    bit [3:0]  seg_log2_q;
    bit [12:0] seg_count_q;
    bit [31:0] seed_q [NUM_HASHES];
    hash_set_t run_hash;
    bit [31:0] run_len;
    bit        key_open;
    bit [7:0]  fp_tab  [DEPTH];
    bit [31:0] val_tab [DEPTH];
    bit        fp_set  [DEPTH];
    bit        val_set [DEPTH];

    out_item_t lookup_expect [$];
    int        fail_count;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        quiet_cycles;

    // Clock: 12 time units.
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic bit [31:0] rotl(bit [31:0] x, int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic bit [31:0] mix_word(bit [31:0] w);
        bit [31:0] m;
        m = w * MIX_C1;
        m = rotl(m, 15);
        m = m * MIX_C2;
        return m;
    endfunction

    function automatic bit [31:0] fmix(bit [31:0] h, bit [31:0] len);
        bit [31:0] f;
        f = h ^ len;
        f = f ^ (f >> 16);
        f = f * FIN_C1;
        f = f ^ (f >> 13);
        f = f * FIN_C2;
        f = f ^ (f >> 16);
        return f;
    endfunction

    // Fold one full word into every running hash.
    function automatic void fold_word(ref hash_set_t s, input bit [31:0] w);
        bit [31:0] t;
        for (int i = 0; i < NUM_HASHES; i++)
        begin
            t = s[i] ^ mix_word(w);
            s[i] = rotl(t, 13) * 32'd5 + MIX_C3;
        end
    endfunction

    // Fold the last word (full or tail) and finalize; len is updated in place.
    function automatic hash_set_t close_key(ref hash_set_t s, ref bit [31:0] len,
                                            input bit [31:0] w, input int nb);
        hash_set_t fin;
        bit [31:0] tail;
        if (nb >= 4)
        begin
            fold_word(s, w);
            len += 32'd4;
        end
        else
        begin
            tail = w & ((32'd1 << (8 * nb)) - 32'd1);
            for (int i = 0; i < NUM_HASHES; i++)
                s[i] ^= mix_word(tail);
            len += 32'(nb);
        end
        for (int i = 0; i < NUM_HASHES; i++)
            fin[i] = fmix(s[i], len);
        return fin;
    endfunction

    function automatic int eff_hashes();
        return (hash_count_q < 3) ? 3 : (hash_count_q > 4) ? 4 : int'(hash_count_q);
    endfunction

    // Form slot locations from final hashes; returns 0 when no table read happens.
    function automatic bit place_slots(hash_set_t h, output int unsigned loc [4]);
        int k;
        longint unsigned first, mask, l;
        k = eff_hashes();
        for (int i = 0; i < 4; i++)
            loc[i] = 0;
        if (fused_q)
        begin
            if (seg_count_q <= k)
                return 0;
            first = (longint'(h[k + 1]) % (seg_count_q - k)) << seg_log2_q;
            mask  = (64'd1 << seg_log2_q) - 1;
            for (int i = 0; i < k; i++)
            begin
                l = first + (longint'(i) << seg_log2_q) + (longint'(h[i]) & mask);
                if (l >= DEPTH)
                    return 0;
                loc[i] = l;
            end
        end
        else
        begin
            if (slot_count_q == 0)
                return 0;
            for (int i = 0; i < k; i++)
            begin
                l = longint'(h[i]) % slot_count_q;
                if (l >= DEPTH)
                    return 0;
                loc[i] = l;
            end
        end
        return 1;
    endfunction

    // Final hashes of a whole key from the current seeds.
    function automatic hash_set_t key_digest(bit [31:0] words [$], int nb);
        hash_set_t s;
        bit [31:0] len;
        len = 0;
        for (int i = 0; i < NUM_HASHES; i++)
            s[i] = seed_q[i];
        for (int n = 0; n < words.size() - 1; n++)
        begin
            fold_word(s, words[n]);
            len += 32'd4;
        end
        return close_key(s, len, words[words.size() - 1], (nb > 4) ? 4 : nb);
    endfunction

    // Advance the shadow copy by one accepted item; queue the result it causes.
    task automatic track_item(in_item_t it);
        hash_set_t h;
        int unsigned loc [4];
        int nb;
        int k;
        bit [7:0] sel;
        out_item_t res;
        if (it.operation == OP_WR_FP)
        begin
            fp_tab[it.slot_index] = it.slot_data;
            fp_set[it.slot_index] = 1'b1;
            return;
        end
        if (it.operation == OP_WR_VAL)
        begin
            val_tab[it.slot_index] = it.new_value;
            val_set[it.slot_index] = 1'b1;
            return;
        end
        if (!key_open)
        begin
            for (int i = 0; i < NUM_HASHES; i++)
                run_hash[i] = seed_q[i];
            run_len  = 0;
            key_open = 1'b1;
        end
        if (!it.key_last)
        begin
            fold_word(run_hash, it.key_word);
            run_len += 32'd4;
            return;
        end
        nb = (it.word_bytes > 4) ? 4 : int'(it.word_bytes);
        h = close_key(run_hash, run_len, it.key_word, nb);
        key_open = 1'b0;
        res = '0;
        k = eff_hashes();
        if (place_slots(h, loc))
        begin
            sel = h[k][7:0];
            for (int i = 0; i < k; i++)
                sel ^= fp_tab[loc[i]];
            if (sel < k)
            begin
                res.found = 1'b1;
                res.slot  = 12'(loc[sel]);
                if (it.operation == OP_SET)
                begin
                    val_tab[loc[sel]] = it.new_value;
                    val_set[loc[sel]] = 1'b1;
                end
                else
                    res.value_out = val_tab[loc[sel]];
            end
        end
        lookup_expect.push_back(res);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // Check every result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (lookup_expect.size() == 0)
                report_mismatch("unexpected result", out_data.value_out, 32'd0);
            else
            begin
                want = lookup_expect.pop_front();
                if (out_data.found !== want.found)
                    report_mismatch("found", 32'(out_data.found), 32'(want.found));
                if (out_data.slot !== want.slot)
                    report_mismatch("slot", 32'(out_data.slot), 32'(want.slot));
                if (out_data.value_out !== want.value_out)
                    report_mismatch("value_out", out_data.value_out, want.value_out);
            end
        end
    end

    // Receiver back-pressure, redrawn each falling edge.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Watchdog: give up when no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("fused_bloomier_filter_lookup regression: fail");
            $finish;
        end
    end

    // Present one item and hold it until the transfer; update the shadow on acceptance.
    task automatic send_item(in_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        track_item(it);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic table_write(logic [1:0] op, int unsigned idx, bit [31:0] d);
        in_item_t it;
        it = '0;
        it.operation  = op;
        it.slot_index = 12'(idx);
        it.slot_data  = d[7:0];
        it.new_value  = d;
        it.key_word   = $urandom;
        send_item(it);
    endtask

    // Load every slot a key will read that has never been written.
    task automatic cover_key(bit [31:0] words [$], int nb);
        int unsigned loc [4];
        int k;
        if (place_slots(key_digest(words, nb), loc))
        begin
            k = eff_hashes();
            for (int i = 0; i < k; i++)
            begin
                if (!fp_set[loc[i]])
                    table_write(OP_WR_FP, loc[i], $urandom);
                if (!val_set[loc[i]])
                    table_write(OP_WR_VAL, loc[i], $urandom);
            end
        end
    endtask

    // Wait until nothing is outstanding and the back end has gone quiet.
    task automatic drain();
        wait (lookup_expect.size() == 0);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_HASH_COUNT:    hash_count_q = d[2:0];
            CFG_FUSED_MODE:    fused_q      = d[0];
            CFG_SLOT_COUNT:    slot_count_q = d[12:0];
            CFG_SEGMENT_LOG2:  seg_log2_q   = d[3:0];
            CFG_SEGMENT_COUNT: seg_count_q  = d[12:0];
            CFG_SEEDS_01:      {seed_q[1], seed_q[0]} = d;
            CFG_SEEDS_23:      {seed_q[3], seed_q[2]} = d;
            default:           {seed_q[5], seed_q[4]} = d;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_layout(bit [2:0] hc, bit fu, bit [12:0] sc, bit [3:0] sl,
                              bit [12:0] sg);
        drain();
        write_reg(CFG_HASH_COUNT, 64'(hc));
        write_reg(CFG_FUSED_MODE, 64'(fu));
        write_reg(CFG_SLOT_COUNT, 64'(sc));
        write_reg(CFG_SEGMENT_LOG2, 64'(sl));
        write_reg(CFG_SEGMENT_COUNT, 64'(sg));
        write_reg(CFG_SEEDS_01, {$urandom, $urandom});
        write_reg(CFG_SEEDS_23, {$urandom, $urandom});
        write_reg(CFG_SEEDS_45, {$urandom, $urandom});
    endtask

    // Send one key. With aim set, first patch the fingerprint table so the key decodes
    // to a chosen location and load a value there. Mixed lookup/set ops on early words.
    task automatic send_key(logic [1:0] op, int nwords, int nb, bit aim, bit mid_write);
        bit [31:0] words [$];
        hash_set_t h;
        int unsigned loc [4];
        int k;
        int j;
        bit [7:0] sel0;
        bit dup;
        in_item_t it;
        for (int n = 0; n < nwords; n++)
            words.push_back($urandom);
        cover_key(words, nb);
        if (aim && place_slots(key_digest(words, nb), loc))
        begin
            h = key_digest(words, nb);
            k = eff_hashes();
            j = $urandom_range(k - 1);
            sel0 = h[k][7:0];
            dup = 1'b0;
            for (int i = 0; i < k; i++)
            begin
                if (i != j)
                begin
                    sel0 ^= fp_tab[loc[i]];
                    if (loc[i] == loc[j])
                        dup = 1'b1;
                end
            end
            if (!dup)
            begin
                table_write(OP_WR_FP, loc[j], 32'(j) ^ 32'(sel0));
                table_write(OP_WR_VAL, loc[j], $urandom);
            end
        end
        for (int n = 0; n < nwords; n++)
        begin
            it = '0;
            it.key_last   = (n == nwords - 1);
            it.operation  = it.key_last ? op : ($urandom_range(1) ? OP_SET : OP_LOOKUP);
            it.key_word   = words[n];
            it.word_bytes = it.key_last ? 3'(nb) : 3'($urandom_range(7));
            it.slot_index = 12'($urandom);
            it.slot_data  = 8'($urandom);
            it.new_value  = $urandom;
            send_item(it);
            // A value write in the middle of a key must leave the key intact.
            if (mid_write && n == 0 && nwords > 1)
                table_write(OP_WR_VAL, $urandom_range(DEPTH - 1), $urandom);
        end
    endtask

    task automatic set_pace(int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
        endcase
    endtask

    // Load the low table entries; keys outside them get their slots loaded on demand.
    task automatic test_table_load();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < LOADED; i++)
        begin
            table_write(OP_WR_FP, i, $urandom);
            table_write(OP_WR_VAL, i, $urandom);
        end
    endtask

    task automatic test_directed();
        // Reset layout: one segment is too few, every key misses.
        send_key(OP_LOOKUP, 1, 4, 1'b0, 1'b0);
        send_key(OP_SET, 2, 2, 1'b0, 1'b0);
        set_layout(3'd3, 1'b0, 13'd4096, 4'd0, 13'd1);
        table_write(OP_WR_FP, 0, 32'h0);
        table_write(OP_WR_FP, DEPTH - 1, 32'hff);
        table_write(OP_WR_VAL, 0, 32'hffff_ffff);
        table_write(OP_WR_VAL, DEPTH - 1, 32'h0);
        send_key(OP_LOOKUP, 1, 0, 1'b1, 1'b0);    // empty key
        send_key(OP_LOOKUP, 1, 1, 1'b1, 1'b0);
        send_key(OP_LOOKUP, 2, 3, 1'b1, 1'b1);
        send_key(OP_SET, 2, 7, 1'b1, 1'b0);       // oversized byte count
        send_key(OP_LOOKUP, 3, 4, 1'b1, 1'b0);
        // Extreme key words.
        begin
            in_item_t it;
            bit [31:0] xw [$];
            xw.push_back(32'hffff_ffff);
            xw.push_back(32'h0);
            cover_key(xw, 4);
            it = '0;
            it.operation = OP_LOOKUP;
            it.key_word = 32'hffff_ffff;
            it.word_bytes = 3'd7;
            it.new_value = 32'hffff_ffff;
            it.slot_index = 12'hfff;
            it.slot_data = 8'hff;
            send_item(it);                        // oversized byte count, not last
            it.key_word = 32'h0;
            it.key_last = 1'b1;
            it.word_bytes = 3'd4;
            send_item(it);
        end
        // Zero slot count and an oversized modulus.
        set_layout(3'd0, 1'b0, 13'd0, 4'd0, 13'd1);
        send_key(OP_LOOKUP, 1, 4, 1'b1, 1'b0);
        set_layout(3'd7, 1'b0, 13'd8191, 4'd0, 13'd1);
        send_key(OP_LOOKUP, 2, 4, 1'b1, 1'b0);
        send_key(OP_SET, 1, 2, 1'b1, 1'b0);
        // Segment count equal to hash count, then the widest segments.
        set_layout(3'd4, 1'b1, 13'd1, 4'd2, 13'd4);
        send_key(OP_LOOKUP, 1, 4, 1'b1, 1'b0);
        set_layout(3'd3, 1'b1, 13'd1, 4'd12, 13'd8191);
        send_key(OP_LOOKUP, 1, 4, 1'b1, 1'b0);
        set_layout(3'd4, 1'b1, 13'd1, 4'd0, 13'd5);
        send_key(OP_LOOKUP, 2, 1, 1'b1, 1'b0);
        send_key(OP_SET, 1, 4, 1'b1, 1'b0);
    endtask

    // Random keys over several layouts and pacing phases.
    task automatic test_random();
        int sl;
        for (int phase = 0; phase < 8; phase++)
        begin
            sl = $urandom_range(2);
            case (phase % 4)
                0: set_layout(3'd3, 1'b0, 13'($urandom_range(1, LOADED)), 4'd0, 13'd1);
                1: set_layout(3'd4, 1'b1, 13'd1, 4'(sl), 13'(LOADED >> sl));
                2: set_layout(3'd4, 1'b0, 13'($urandom_range(1, LOADED)), 4'd0, 13'd1);
                default: set_layout(3'd3, 1'b1, 13'd1, 4'(sl),
                                    13'($urandom_range(4, LOADED >> sl)));
            endcase
            set_pace(phase);
            for (int n = 0; n < 12; n++)
            begin
                if ($urandom_range(99) < 75)
                    send_key($urandom_range(1) ? OP_SET : OP_LOOKUP, $urandom_range(1, 3),
                             $urandom_range(7), 1'b1, $urandom_range(9) == 0);
                else if ($urandom_range(1))
                    table_write($urandom_range(1) ? OP_WR_FP : OP_WR_VAL,
                                $urandom_range(LOADED - 1), $urandom);
                else
                    send_key($urandom_range(1) ? OP_SET : OP_LOOKUP, $urandom_range(1, 2),
                             $urandom_range(7), 1'b0, 1'b0);
                // Hold off once per phase until the pipe is empty.
                if (n == 6)
                    wait (lookup_expect.size() == 0);
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_stall      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_HASH_COUNT;
        cfg_data       = '0;
        fail_count     = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hash_count_q   = 3'd3;
        fused_q        = 1'b1;
        slot_count_q   = 13'd4096;
        seg_log2_q     = 4'd0;
        seg_count_q    = 13'd1;
        key_open       = 1'b0;
        run_len        = 0;
        for (int i = 0; i < NUM_HASHES; i++)
        begin
            seed_q[i]   = 0;
            run_hash[i] = 0;
        end
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_table_load();
        test_directed();
        test_random();

        drain();
        if (fail_count == 0)
            $display("fused_bloomier_filter_lookup regression: pass");
        else
            $display("fused_bloomier_filter_lookup regression: fail");
        $finish;
    end

endmodule
